// ----- rtl/salru_pkg.sv -----
// shared constants and types for the lru cache lookup unit
`timescale 1ns / 1ps
package salru_pkg;
	localparam int MAX_WAYS = 8;
	localparam int MAX_SETS = 64;
	localparam int ADDR_W = 31;
	localparam int STAMP_W = 32;
	localparam int WAYS_CFG_W = 4;
	localparam int SETS_CFG_W = 7;
	localparam int SET_OUT_W = 6;
	localparam int WAY_OUT_W = 3;
	localparam logic [0:0] REG_WAYS = 1'b0;
	localparam logic [0:0] REG_SETS = 1'b1;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_DIV,
		FR_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_READ,
		BK_SCAN,
		BK_WRITE,
		BK_DONE,
		BK_CLEAR
	} back_state_t;
endpackage

// ----- rtl/salru_ram.sv -----
// generic ram with one write port and a registered read port
`timescale 1ns / 1ps
module salru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/salru_front.sv -----
// front end: accepts addresses and computes the set by restoring division
`timescale 1ns / 1ps
module salru_front #(
	parameter int MAX_SETS = salru_pkg::MAX_SETS,
	parameter int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [salru_pkg::ADDR_W-1:0]         block_address,
	input  logic [salru_pkg::SETS_CFG_W-1:0]     sets_eff,
	output logic                                 q_push,
	output logic [salru_pkg::ADDR_W-1:0]         q_addr,
	output logic [SET_W-1:0]                     q_set,
	input  logic                                 q_full
);
	localparam int AW = salru_pkg::ADDR_W;
	localparam int RW = salru_pkg::SETS_CFG_W + 1;
	localparam int CW = $clog2(AW + 1);

	salru_pkg::front_state_t state_q, state_d;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] quo_q;
	logic [RW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic [RW-1:0] trial;
	logic [RW-1:0] div_q;

	assign trial = {rem_q[RW-2:0], quo_q[AW-1]};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			salru_pkg::FR_IDLE: if (start) state_d = salru_pkg::FR_DIV;
			salru_pkg::FR_DIV:  if (cnt_q == CW'(AW - 1)) state_d = salru_pkg::FR_PUSH;
			salru_pkg::FR_PUSH: if (!q_full) state_d = salru_pkg::FR_IDLE;
			default: state_d = salru_pkg::FR_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy = 1'b1;
		q_push = 1'b0;
		case (state_q)
			salru_pkg::FR_IDLE: busy = 1'b0;
			salru_pkg::FR_PUSH: q_push = !q_full;
			default: busy = 1'b1;
		endcase
	end

	assign q_addr = addr_q;
	assign q_set = SET_W'(rem_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= salru_pkg::FR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// one remainder bit per cycle
	always_ff @(posedge clk) begin
		if (state_q == salru_pkg::FR_IDLE && start) begin
			addr_q <= block_address;
			quo_q <= block_address;
			rem_q <= '0;
			cnt_q <= '0;
			div_q <= RW'(sets_eff);
		end else if (state_q == salru_pkg::FR_DIV) begin
			quo_q <= {quo_q[AW-2:0], 1'b0};
			cnt_q <= cnt_q + CW'(1);
			if (trial >= div_q) begin
				rem_q <= trial - div_q;
			end else begin
				rem_q <= trial;
			end
		end
	end

	// the remainder always stays below the divisor
	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == salru_pkg::FR_PUSH |-> rem_q < div_q) else $error("rem out of range");
	a_push: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |=> state_q == salru_pkg::FR_IDLE) else $error("push without release");
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> state_q == salru_pkg::FR_DIV) else $error("start lost");
endmodule

// ----- rtl/salru_back.sv -----
// back end: valid clear after reset, set lookup, lru selection and line update
`timescale 1ns / 1ps
module salru_back #(
	parameter int MAX_WAYS = salru_pkg::MAX_WAYS,
	parameter int MAX_SETS = salru_pkg::MAX_SETS,
	parameter int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
	parameter int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	output logic                              q_pop,
	input  logic [salru_pkg::ADDR_W-1:0]      q_addr,
	input  logic [SET_W-1:0]                  q_set,
	input  logic [salru_pkg::WAYS_CFG_W-1:0]  ways_eff,
	output logic                              done,
	output logic                              hit,
	output logic [salru_pkg::SET_OUT_W-1:0]   set_index,
	output logic [salru_pkg::WAY_OUT_W-1:0]   way
);
	localparam int AW = salru_pkg::ADDR_W;
	localparam int SW = salru_pkg::STAMP_W;
	localparam int LINES = MAX_WAYS * MAX_SETS;
	localparam int LW = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int WC = $clog2(MAX_WAYS + 1);

	salru_pkg::back_state_t state_q, state_d;
	logic [SW-1:0] counter_q;
	logic [LW-1:0] clr_q;
	logic [AW-1:0] addr_q;
	logic [SET_W-1:0] set_q;
	logic [WC-1:0] w_q;
	logic [WC-1:0] nw_q;
	logic hit_q, empty_q;
	logic [WAY_W-1:0] chosen_q;
	logic [SW-1:0] least_q;
	logic [AW-1:0] rd_addr;
	logic [SW-1:0] rd_stamp;
	logic rd_valid;
	logic [LW-1:0] raddr, waddr;
	logic we_addr, we_stamp;
	logic v_we, v_wdata;
	logic [LW-1:0] v_waddr;
	logic [WAY_W-1:0] cur_w, rd_w;
	logic [LW-1:0] cur_line;
	logic rd_pend_q;
	logic [WC-1:0] rw_q;

	assign cur_w = WAY_W'(w_q);
	assign rd_w = WAY_W'(rw_q);
	assign cur_line = LW'(set_q) * LW'(MAX_WAYS) + LW'(cur_w);
	assign raddr = cur_line;
	assign waddr = LW'(set_q) * LW'(MAX_WAYS) + LW'(chosen_q);
	assign we_addr = state_q == salru_pkg::BK_WRITE && !hit_q;
	assign we_stamp = state_q == salru_pkg::BK_WRITE;

	// valid bits: cleared line by line after reset, set on fill
	assign v_we = we_stamp || state_q == salru_pkg::BK_CLEAR;
	assign v_waddr = (state_q == salru_pkg::BK_CLEAR) ? clr_q : waddr;
	assign v_wdata = state_q != salru_pkg::BK_CLEAR;

	salru_ram #(.WIDTH(AW), .DEPTH(LINES)) u_addr_ram (
		.clk(clk), .we(we_addr), .waddr(waddr), .wdata(addr_q),
		.raddr(raddr), .rdata(rd_addr)
	);
	salru_ram #(.WIDTH(SW), .DEPTH(LINES)) u_stamp_ram (
		.clk(clk), .we(we_stamp), .waddr(waddr), .wdata(counter_q),
		.raddr(raddr), .rdata(rd_stamp)
	);
	salru_ram #(.WIDTH(1), .DEPTH(LINES)) u_valid_ram (
		.clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
		.raddr(raddr), .rdata(rd_valid)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			salru_pkg::BK_CLEAR: if (clr_q == LW'(LINES - 1)) state_d = salru_pkg::BK_IDLE;
			salru_pkg::BK_IDLE: if (q_valid) state_d = salru_pkg::BK_READ;
			salru_pkg::BK_READ: state_d = salru_pkg::BK_SCAN;
			salru_pkg::BK_SCAN: if (rd_pend_q && (rw_q == nw_q - WC'(1) ||
				(rd_valid && rd_addr == addr_q))) state_d = salru_pkg::BK_WRITE;
			salru_pkg::BK_WRITE: state_d = salru_pkg::BK_DONE;
			salru_pkg::BK_DONE: state_d = salru_pkg::BK_IDLE;
			default: state_d = salru_pkg::BK_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_pop = 1'b0;
		done = 1'b0;
		case (state_q)
			salru_pkg::BK_IDLE: q_pop = q_valid;
			salru_pkg::BK_DONE: done = 1'b1;
			default: q_pop = 1'b0;
		endcase
	end

	assign hit = hit_q;
	assign set_index = salru_pkg::SET_OUT_W'(set_q);
	assign way = salru_pkg::WAY_OUT_W'(chosen_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= salru_pkg::BK_CLEAR;
			clr_q <= '0;
			counter_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == salru_pkg::BK_CLEAR) begin
				clr_q <= clr_q + LW'(1);
			end
			if (state_q == salru_pkg::BK_READ && counter_q != '1) begin
				counter_q <= counter_q + SW'(1);
			end
		end
	end

	// way scan: one read issued per cycle, the previous read checked
	always_ff @(posedge clk) begin
		case (state_q)
			salru_pkg::BK_IDLE: begin
				addr_q <= q_addr;
				set_q <= q_set;
				nw_q <= WC'(ways_eff);
				w_q <= '0;
			end
			salru_pkg::BK_READ: begin
				hit_q <= 1'b0;
				empty_q <= 1'b0;
				chosen_q <= '0;
				least_q <= '1;
				rd_pend_q <= 1'b1;
				rw_q <= w_q;
				if (w_q != nw_q - WC'(1)) w_q <= w_q + WC'(1);
			end
			salru_pkg::BK_SCAN: begin
				rw_q <= w_q;
				if (w_q != nw_q - WC'(1)) w_q <= w_q + WC'(1);
				if (rd_valid && rd_addr == addr_q) begin
					hit_q <= 1'b1;
					chosen_q <= rd_w;
				end else if (!hit_q && !empty_q) begin
					if (!rd_valid) begin
						empty_q <= 1'b1;
						chosen_q <= rd_w;
					end else if (rw_q == '0 || rd_stamp < least_q) begin
						least_q <= rd_stamp;
						chosen_q <= rd_w;
					end
				end
			end
			default: rd_pend_q <= 1'b1;
		endcase
	end

	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> state_q == salru_pkg::BK_IDLE) else $error("done held");
	a_way: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> WC'(chosen_q) < nw_q) else $error("way out of range");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == salru_pkg::BK_CLEAR |-> !q_pop && !done) else $error("work during clear");
endmodule

// ----- rtl/set_associative_lru_cache_lookup_unit.sv -----
// top level of the set associative lru cache lookup unit
// an address passes the set division and the queue push, then the back end way scan and line update
// the divider takes a new address only once it has pushed the last one; the back end overlaps it
// the one-entry queue lets the divider start the next address while the back end works
// reset clears the stamp counter, sets eight ways and 64 sets, then a pass over all
// MAX_SETS * MAX_WAYS lines (512 by default) clears the valid bits; strobes cannot stall
`timescale 1ns / 1ps
module set_associative_lru_cache_lookup_unit #(
	parameter int MAX_WAYS = salru_pkg::MAX_WAYS,
	parameter int MAX_SETS = salru_pkg::MAX_SETS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [salru_pkg::ADDR_W-1:0]         block_address,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [0:0]                           cfg_index,
	input  logic [salru_pkg::SETS_CFG_W-1:0]     cfg_data,
	output logic                                 done,
	output logic                                 hit,
	output logic [salru_pkg::SET_OUT_W-1:0]      set_index,
	output logic [salru_pkg::WAY_OUT_W-1:0]      way
);
	localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int AW = salru_pkg::ADDR_W;

	logic [salru_pkg::WAYS_CFG_W-1:0] ways_q, ways_eff;
	logic [salru_pkg::SETS_CFG_W-1:0] sets_q, sets_eff;
	logic f_push, q_full, b_pop;
	logic [AW-1:0] f_addr, q_addr_q;
	logic [SET_W-1:0] f_set, q_set_q;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ways_q <= salru_pkg::WAYS_CFG_W'(8);
			sets_q <= salru_pkg::SETS_CFG_W'(64);
		end else if (cfg_valid) begin
			if (cfg_index == salru_pkg::REG_WAYS) begin
				ways_q <= cfg_data[salru_pkg::WAYS_CFG_W-1:0];
			end else begin
				sets_q <= cfg_data;
			end
		end
	end

	// clamp configured counts to legal range
	assign ways_eff = (ways_q == '0) ? salru_pkg::WAYS_CFG_W'(1) :
		(32'(ways_q) > MAX_WAYS) ? salru_pkg::WAYS_CFG_W'(MAX_WAYS) : ways_q;
	assign sets_eff = (sets_q == '0) ? salru_pkg::SETS_CFG_W'(1) :
		(32'(sets_q) > MAX_SETS) ? salru_pkg::SETS_CFG_W'(MAX_SETS) : sets_q;

	salru_front #(.MAX_SETS(MAX_SETS), .SET_W(SET_W)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.block_address(block_address), .sets_eff(sets_eff),
		.q_push(f_push), .q_addr(f_addr), .q_set(f_set), .q_full(q_full)
	);

	// one-entry queue between front and back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_full <= 1'b0;
		end else if (f_push) begin
			q_full <= 1'b1;
		end else if (b_pop) begin
			q_full <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (f_push) begin
			q_addr_q <= f_addr;
			q_set_q <= f_set;
		end
	end

	salru_back #(.MAX_WAYS(MAX_WAYS), .MAX_SETS(MAX_SETS), .SET_W(SET_W)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_full), .q_pop(b_pop),
		.q_addr(q_addr_q), .q_set(q_set_q), .ways_eff(ways_eff),
		.done(done), .hit(hit), .set_index(set_index), .way(way)
	);

	a_nopush_full: assert property (@(posedge clk) disable iff (!arst_n)
		f_push |-> !q_full) else $error("queue overflow");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		b_pop |-> q_full) else $error("queue underflow");
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		ways_eff != '0 && sets_eff != '0) else $error("zero count");
endmodule
